>>> rtl/xrm_pkg.sv
// Shared types and constants for the register/memory instruction encoder.
package xrm_pkg;

   localparam int MaxBytes   = 10;
   localparam int QueueDepth = 2;
   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);
   localparam int IdxWidth   = $clog2(MaxBytes + 1);

   localparam logic [3:0] OPSIZE_WORD   = 4'd2;
   localparam logic [3:0] OPSIZE_QWORD  = 4'd8;
   localparam logic [7:0] PREFIX_OPSIZE = 8'h66;
   localparam logic [7:0] REX_BASE      = 8'h40;

   localparam logic [1:0] MOD_DISP8  = 2'd1;
   localparam logic [1:0] MOD_DISP32 = 2'd2;
   localparam logic [1:0] MOD_REG    = 2'd3;

   typedef logic [MaxBytes-1:0][7:0] byte_vec_type;

   // One fully laid out instruction: bytes in emit order plus how many
   typedef struct packed {
      byte_vec_type          bytes;
      logic [IdxWidth-1:0]   count;
   } desc_type;

endpackage

>>> rtl/xrm_front.sv
// Front end: classifies a request and lays out its machine-code bytes.
module xrm_front (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_mode,
   input  logic [3:0]        req_operand_size,
   input  logic [23:0]       req_opcode,
   input  logic [3:0]        req_reg_field,
   input  logic [3:0]        req_rm_register,
   input  logic [31:0]       req_displacement,
   input  logic              queue_full,
   output logic              push,
   output xrm_pkg::desc_type push_desc
);

   logic                          small_disp;
   logic                          need_rex;
   logic [7:0]                    rex_byte;
   logic [1:0]                    mod_bits;
   logic [7:0]                    modrm_byte;
   xrm_pkg::byte_vec_type         bytes_v;
   logic [xrm_pkg::IdxWidth-1:0]  pos_v;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // disp fits in a signed byte when bits 31..7 are all equal
   assign small_disp = (req_displacement[31:7] == '0) || (req_displacement[31:7] == '1);

   assign need_rex = (req_operand_size == xrm_pkg::OPSIZE_QWORD) ||
                     req_reg_field[3] || req_rm_register[3];
   assign rex_byte = xrm_pkg::REX_BASE |
                     {4'd0, (req_operand_size == xrm_pkg::OPSIZE_QWORD),
                      req_reg_field[3], 1'b0, req_rm_register[3]};

   assign mod_bits   = !req_mode ? xrm_pkg::MOD_REG :
                       (small_disp ? xrm_pkg::MOD_DISP8 : xrm_pkg::MOD_DISP32);
   assign modrm_byte = {mod_bits, req_reg_field[2:0], req_rm_register[2:0]};

   always_comb begin
      bytes_v = '0;
      pos_v   = '0;
      if (req_operand_size == xrm_pkg::OPSIZE_WORD) begin
         bytes_v[pos_v] = xrm_pkg::PREFIX_OPSIZE;
         pos_v          = pos_v + 1'b1;
      end
      if (need_rex) begin
         bytes_v[pos_v] = rex_byte;
         pos_v          = pos_v + 1'b1;
      end
      bytes_v[pos_v] = req_opcode[7:0];
      pos_v          = pos_v + 1'b1;
      if (req_opcode[23:8] != '0) begin
         bytes_v[pos_v] = req_opcode[15:8];
         pos_v          = pos_v + 1'b1;
      end
      if (req_opcode[23:16] != '0) begin
         bytes_v[pos_v] = req_opcode[23:16];
         pos_v          = pos_v + 1'b1;
      end
      bytes_v[pos_v] = modrm_byte;
      pos_v          = pos_v + 1'b1;
      if (req_mode) begin
         bytes_v[pos_v] = req_displacement[7:0];
         pos_v          = pos_v + 1'b1;
         if (!small_disp) begin
            bytes_v[pos_v] = req_displacement[15:8];
            pos_v          = pos_v + 1'b1;
            bytes_v[pos_v] = req_displacement[23:16];
            pos_v          = pos_v + 1'b1;
            bytes_v[pos_v] = req_displacement[31:24];
            pos_v          = pos_v + 1'b1;
         end
      end
      push_desc.bytes = bytes_v;
      push_desc.count = pos_v;
   end

endmodule

>>> rtl/xrm_queue.sv
// Small descriptor queue between the front end and the byte serializer.
module xrm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  xrm_pkg::desc_type push_desc,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output xrm_pkg::desc_type pop_desc
);

   xrm_pkg::desc_type               slot_ff [xrm_pkg::QueueDepth];
   logic [xrm_pkg::PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [xrm_pkg::PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [xrm_pkg::CountWidth-1:0]  count_ff, count_in;
   logic                            do_pop;

   assign full      = (count_ff == xrm_pkg::CountWidth'(xrm_pkg::QueueDepth));
   assign not_empty = (count_ff != '0);
   assign do_pop    = pop && not_empty;
   assign pop_desc  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + xrm_pkg::CountWidth'(push) - xrm_pkg::CountWidth'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

>>> rtl/xrm_back.sv
// Back end: walks one descriptor a byte per cycle into the output register, unless the output is stalled.
module xrm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_not_empty,
   input  xrm_pkg::desc_type queue_desc,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_code_byte,
   output logic              rsp_last_byte
);

   xrm_pkg::desc_type             cur_ff, cur_in;
   logic [xrm_pkg::IdxWidth-1:0]  idx_ff, idx_in;
   logic                          busy_ff, busy_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    code_ff, code_in;
   logic                          last_ff, last_in;
   logic                          out_free;
   logic                          at_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign at_last  = (idx_ff == cur_ff.count - 1'b1);
   // refill as soon as the final byte moves into the output register
   assign pop      = queue_not_empty && (!busy_ff || (out_free && at_last));

   always_comb begin
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      code_in      = code_ff;
      last_in      = last_ff;
      if (out_free) begin
         rsp_valid_in = busy_ff;
         code_in      = cur_ff.bytes[idx_ff[xrm_pkg::IdxWidth-1:0]];
         last_in      = at_last;
         if (busy_ff) begin
            idx_in = idx_ff + 1'b1;
            if (at_last) begin
               busy_in = 1'b0;
            end
         end
      end
      if (pop) begin
         cur_in  = queue_desc;
         idx_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      code_ff <= code_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code_byte = code_ff;
   assign rsp_last_byte = last_ff;

endmodule

>>> rtl/x86_register_memory_instruction_encoder_core.sv
// Top level of the x86-64 register/memory instruction encoder.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    mode, operand_size, opcode, reg_field,
//                                          rm_register, displacement
//   rsp      out        rsp_valid/stall    code_byte, last_byte (one byte per transfer)
//
// An instruction yields 2 to 10 bytes, one rsp transfer per cycle while rsp_stall is
// low; the byte serializer sets that pace.
// The first byte passes the queue slot and the descriptor register, then the output register.
// A two-entry queue holds laid-out instructions; req_stall rises only when it is full.
// Reset is synchronous and clears the queue, serializer and output valid.
module x86_register_memory_instruction_encoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [3:0]  req_operand_size,
   input  logic [23:0] req_opcode,
   input  logic [3:0]  req_reg_field,
   input  logic [3:0]  req_rm_register,
   input  logic [31:0] req_displacement,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_code_byte,
   output logic        rsp_last_byte
);

   logic              queue_full;
   logic              push;
   xrm_pkg::desc_type push_desc;
   logic              pop;
   logic              queue_not_empty;
   xrm_pkg::desc_type pop_desc;

   xrm_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_operand_size (req_operand_size),
      .req_opcode       (req_opcode),
      .req_reg_field    (req_reg_field),
      .req_rm_register  (req_rm_register),
      .req_displacement (req_displacement),
      .queue_full       (queue_full),
      .push             (push),
      .push_desc        (push_desc)
   );

   xrm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_desc  (pop_desc)
   );

   xrm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_desc      (pop_desc),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_byte   (rsp_code_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule

>>> rtl/xrm_checker.sv
// Port-level checks for the instruction encoder, bound to the top level.
module xrm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_mode,
   input logic [3:0]  req_operand_size,
   input logic [23:0] req_opcode,
   input logic [3:0]  req_reg_field,
   input logic [3:0]  req_rm_register,
   input logic [31:0] req_displacement,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_code_byte,
   input logic        rsp_last_byte
);

   // stalled result byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_byte) &&
                                 $stable(rsp_last_byte))
      else $error("rsp payload changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // every instruction has at least opcode and ModRM, so two lasts never abut
   a_last_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_byte |=> !(rsp_valid && rsp_last_byte))
      else $error("back-to-back last bytes");

   // nothing comes out of the encoder while it is still empty after reset
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !rsp_valid |=> !rsp_valid)
      else $error("rsp_valid without any request");

endmodule

bind x86_register_memory_instruction_encoder_core xrm_checker u_xrm_checker (.*);
